@@ hw/rtl/gwm_pkg.sv @@
package gwm_pkg;

    // default sizing
    localparam int C_PATTERN_CHARS = 16;
    localparam int C_CHAR_BITS     = 8;
    localparam int C_QDEPTH        = 2;

    // configuration register fields
    localparam int C_CFG_DATA_W = 64;
    localparam int C_CFG_IDX_W  = 2;
    localparam int C_LEN_W      = 5;

    // configuration register indexes
    localparam logic [C_CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
    localparam logic [C_CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;
    localparam logic [C_CFG_IDX_W-1:0] CFG_SEP_MODE = 2'd3;

    // request codes
    localparam logic [1:0] REQ_EMPTY = 2'd0;
    localparam logic [1:0] REQ_FIRST = 2'd1;
    localparam logic [1:0] REQ_NEXT  = 2'd2;

    // special characters
    localparam logic [7:0] C_STAR  = 8'h2A;
    localparam logic [7:0] C_QMARK = 8'h3F;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_COLON = 8'h3A;

    // request class handed from front to back
    typedef struct packed {
        logic start;    // reset the position set to the closed start set
        logic cons;     // consume the character
    } t_req_cls;

endpackage

@@ hw/rtl/gwm_fifo.sv @@
module gwm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = gwm_pkg::C_QDEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/gwm_front.sv @@
module gwm_front #(
    parameter int PATTERN_CHARS = gwm_pkg::C_PATTERN_CHARS,
    parameter int CHAR_BITS     = gwm_pkg::C_CHAR_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gwm_pkg::C_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gwm_pkg::C_CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]                       i_req_type,
    input  logic [7:0]                       i_value_char,
    output gwm_pkg::t_req_cls                o_cls,
    output logic [PATTERN_CHARS-1:0]         o_stay,
    output logic [PATTERN_CHARS-1:0]         o_adv,
    output logic [PATTERN_CHARS-1:0]         o_jump1,
    output logic [PATTERN_CHARS-1:0]         o_jump2,
    output logic [PATTERN_CHARS:0]           o_len_hot
);

    localparam int P  = PATTERN_CHARS;
    localparam int LW = $clog2(P + 1);
    localparam logic [7:0] CMASK = (CHAR_BITS >= 8) ? 8'hFF : 8'((1 << CHAR_BITS) - 1);

    logic [63:0]                  r_pat_low;
    logic [63:0]                  r_pat_high;
    logic [gwm_pkg::C_LEN_W-1:0]  r_pat_len;
    logic                         r_sep_mode;

    logic [LW-1:0] used;
    logic [7:0]    vchar;
    logic          sep_ok;
    logic [P-1:0]  in_len, is_star, is_q, is_eq, is_dstar;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
            r_sep_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gwm_pkg::CFG_PAT_LOW:  r_pat_low  <= i_cfg_data;
                gwm_pkg::CFG_PAT_HIGH: r_pat_high <= i_cfg_data;
                gwm_pkg::CFG_PAT_LEN:  r_pat_len  <= i_cfg_data[gwm_pkg::C_LEN_W-1:0];
                gwm_pkg::CFG_SEP_MODE: r_sep_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign used   = (32'(r_pat_len) > P) ? LW'(P) : LW'(r_pat_len);
    assign vchar  = i_value_char & CMASK;
    assign sep_ok = !(r_sep_mode && (vchar == gwm_pkg::C_SLASH || vchar == gwm_pkg::C_DOT
                                     || vchar == gwm_pkg::C_COLON));

    // request class
    always_comb begin
        o_cls = '0;
        unique case (i_req_type)
            gwm_pkg::REQ_EMPTY: o_cls.start = 1'b1;
            gwm_pkg::REQ_FIRST: begin
                o_cls.start = 1'b1;
                o_cls.cons  = 1'b1;
            end
            gwm_pkg::REQ_NEXT:  o_cls.cons = 1'b1;
            default: ;
        endcase
    end

    for (genvar k = 0; k < P; k++) begin : g_pos
        logic [7:0] pbyte, pc;
        if (k < 8) begin : g_low
            assign pbyte = r_pat_low[8*k +: 8];
        end else if (k < 16) begin : g_high
            assign pbyte = r_pat_high[8*(k-8) +: 8];
        end else begin : g_none
            assign pbyte = 8'h00;
        end
        assign pc         = pbyte & CMASK;
        assign in_len[k]  = (32'(used) > k);
        assign is_star[k] = (pc == (gwm_pkg::C_STAR & CMASK));
        assign is_q[k]    = (pc == (gwm_pkg::C_QMARK & CMASK));
        assign is_eq[k]   = (pc == vchar);
        if (k + 1 < P) begin : g_dnext
            assign is_dstar[k] = is_star[k] && is_star[k+1] && (32'(used) > k + 1);
        end else begin : g_dlast
            assign is_dstar[k] = 1'b0;
        end
        // per-position moves for this character
        assign o_stay[k]  = in_len[k] && is_star[k] && (is_dstar[k] || sep_ok);
        assign o_adv[k]   = in_len[k] && !is_star[k]
                            && ((is_q[k] && sep_ok) || (!is_q[k] && is_eq[k]));
        // star skips, fixed by the pattern
        assign o_jump1[k] = in_len[k] && is_star[k] && !is_dstar[k];
        assign o_jump2[k] = in_len[k] && is_star[k] && is_dstar[k];
    end

    for (genvar j = 0; j <= P; j++) begin : g_len
        assign o_len_hot[j] = (32'(used) == j);
    end

endmodule

@@ hw/rtl/gwm_back.sv @@
module gwm_back #(
    parameter int PATTERN_CHARS = gwm_pkg::C_PATTERN_CHARS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  gwm_pkg::t_req_cls        i_cls,
    input  logic [PATTERN_CHARS-1:0] i_stay,
    input  logic [PATTERN_CHARS-1:0] i_adv,
    input  logic [PATTERN_CHARS-1:0] i_jump1,
    input  logic [PATTERN_CHARS-1:0] i_jump2,
    input  logic [PATTERN_CHARS:0]   i_len_hot,
    input  logic                     i_out_full,
    output logic                     o_take,
    output logic                     o_whole_match
);

    localparam int P   = PATTERN_CHARS;
    localparam int POS = P + 1;

    logic [POS-1:0] r_active, n_active;
    logic [POS-1:0] start_set, base, stepped;

    // forward star closure, one ascending pass
    function automatic logic [POS-1:0] f_close(input logic [POS-1:0] s_in,
                                               input logic [P-1:0]   j1,
                                               input logic [P-1:0]   j2);
        logic [POS:0] s;
        s = {1'b0, s_in};
        for (int i = 0; i < P; i++) begin
            if (s[i] && j1[i]) s[i+1] = 1'b1;
            if (s[i] && j2[i]) s[i+2] = 1'b1;
        end
        return s[POS-1:0];
    endfunction

    assign o_take = i_valid && !i_out_full;

    always_comb begin
        start_set = f_close(POS'(1), i_jump1, i_jump2);
        base      = i_cls.start ? start_set : r_active;
        stepped   = '0;
        for (int i = 0; i < P; i++) begin
            if (base[i] && i_stay[i]) stepped[i]   = 1'b1;
            if (base[i] && i_adv[i])  stepped[i+1] = 1'b1;
        end
        n_active      = i_cls.cons ? f_close(stepped, i_jump1, i_jump2) : base;
        o_whole_match = |(n_active & i_len_hot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (o_take) begin
            r_active <= n_active;
        end
    end

endmodule

@@ hw/rtl/glob_wildcard_matcher.sv @@
// each request is registered in the request queue, its result in the result queue
// throughput: one transaction per cycle unless the result queue is full, set by the
// back-stage position-set update; both queues, of two entries each, absorb stalls
// reset (synchronous, active low) clears the pattern registers, the position set
// and both queues; full and empty read low and high the cycle after reset
module glob_wildcard_matcher #(
    parameter int PATTERN_CHARS = gwm_pkg::C_PATTERN_CHARS,
    parameter int CHAR_BITS     = gwm_pkg::C_CHAR_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [gwm_pkg::C_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gwm_pkg::C_CFG_DATA_W-1:0] i_cfg_data,
    // request side
    input  logic                             push,
    output logic                             full,
    input  logic [1:0]                       i_req_type,
    input  logic [7:0]                       i_value_char,
    // result side
    output logic                             empty,
    input  logic                             pop,
    output logic                             o_whole_match
);

    localparam int P  = PATTERN_CHARS;
    localparam int QW = $bits(gwm_pkg::t_req_cls) + 2 * P;

    // front: classified request and per-position moves
    gwm_pkg::t_req_cls f_cls;
    logic [P-1:0]      f_stay, f_adv;
    // pattern-only decode; the user keeps it stable while transactions are in flight; the block does not enforce it
    logic [P-1:0]      jump1, jump2;
    logic [P:0]        len_hot;

    // queue between front and back
    logic [QW-1:0]     q_wdata, q_rdata;
    logic              q_empty;

    // back side
    gwm_pkg::t_req_cls b_cls;
    logic [P-1:0]      b_stay, b_adv;
    logic              b_take, b_match;
    logic              out_full;

    gwm_front #(
        .PATTERN_CHARS (PATTERN_CHARS),
        .CHAR_BITS     (CHAR_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_req_type   (i_req_type),
        .i_value_char (i_value_char),
        .o_cls        (f_cls),
        .o_stay       (f_stay),
        .o_adv        (f_adv),
        .o_jump1      (jump1),
        .o_jump2      (jump2),
        .o_len_hot    (len_hot)
    );

    assign q_wdata = {f_cls, f_stay, f_adv};

    // request queue, full here is the port's back-pressure
    gwm_fifo #(
        .WIDTH (QW)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .o_full  (full),
        .i_pop   (b_take),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    assign {b_cls, b_stay, b_adv} = q_rdata;

    // back: owns the reachable position set
    gwm_back #(
        .PATTERN_CHARS (PATTERN_CHARS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (!q_empty),
        .i_cls         (b_cls),
        .i_stay        (b_stay),
        .i_adv         (b_adv),
        .i_jump1       (jump1),
        .i_jump2       (jump2),
        .i_len_hot     (len_hot),
        .i_out_full    (out_full),
        .o_take        (b_take),
        .o_whole_match (b_match)
    );

    // result queue, decouples the back from the consumer
    gwm_fifo #(
        .WIDTH (1)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_take),
        .i_data  (b_match),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_whole_match)
    );

endmodule

@@ hw/rtl/gwm_checker.sv @@
module gwm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic push,
    input logic full,
    input logic empty,
    input logic pop,
    input logic o_whole_match
);

    logic [2:0] r_cnt;
    logic       in_acc, out_acc;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    // transactions accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc && !out_acc) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (out_acc && !in_acc) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    a_reset_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (empty && !full))
        else $error("queues not clear after reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_whole_match)))
        else $error("waiting result changed or vanished");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_cnt != 3'd0))
        else $error("result shown with no transaction in flight");

    a_full_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (r_cnt >= 3'd2))
        else $error("full raised with request queue not occupied");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_whole_match (o_whole_match)
);

@@ verif/tb.sv @@
module tb;

    // sizing and run control
    localparam int PAT         = gwm_pkg::C_PATTERN_CHARS;
    localparam int ITEM_TARGET = 1650;
    localparam int IDLE_LIMIT  = 1000;
    // request code the block leaves undecoded: state kept, match reported
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef logic [PAT:0] t_pos;

    // dut inputs, all known from time zero
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [gwm_pkg::C_CFG_IDX_W-1:0]  i_cfg_index = gwm_pkg::CFG_PAT_LOW;
    logic [gwm_pkg::C_CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic        push         = 1'b0;
    logic [1:0]  i_req_type   = gwm_pkg::REQ_EMPTY;
    logic [7:0]  i_value_char = 8'h00;
    logic        pop          = 1'b0;
    // dut outputs
    logic        full;
    logic        empty;
    logic        o_whole_match;

    // shadow copy of the configuration and of the reachable position set
    logic [63:0] cfg_lo;
    logic [63:0] cfg_hi;
    logic [4:0]  cfg_len;
    logic        cfg_sep;
    t_pos        reach_set;

    // predicted whole_match bits, oldest first
    logic        match_pred_q[$];
    int          mismatch_count = 0;
    int          sent_items     = 0;
    int          idle_cycles    = 0;
    bit          tx_calm        = 1'b0;
    bit          rx_calm        = 1'b0;

    // stimulus scratch: pattern bytes of the current phase and one value string
    logic [7:0]  pat_b [0:PAT-1];
    logic [7:0]  word_q[$];

    glob_wildcard_matcher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_req_type    (i_req_type),
        .i_value_char  (i_value_char),
        .empty         (empty),
        .pop           (pop),
        .o_whole_match (o_whole_match)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // matcher prediction
    // ---------------------------------------------------------------

    // pattern character k from the shadow registers, zero past the registers
    function automatic logic [7:0] pat_char_at(int k);
        if (k < 8) return cfg_lo[8*k +: 8];
        if (k < 16) return cfg_hi[8*(k-8) +: 8];
        return 8'h00;
    endfunction

    // lengths above the pattern capacity are clamped
    function automatic int live_len();
        return (int'(cfg_len) > PAT) ? PAT : int'(cfg_len);
    endfunction

    // a star directly followed by a star inside the used length
    function automatic bit pairs_star(int i, int n);
        return (i + 1 < n) && (pat_char_at(i + 1) == gwm_pkg::C_STAR);
    endfunction

    // forward skips over stars; one ascending pass is enough
    function automatic t_pos close_skips(t_pos s, int n);
        int nxt;
        for (int i = 0; i < n; i++) begin
            if (s[i] && pat_char_at(i) == gwm_pkg::C_STAR) begin
                nxt = i + (pairs_star(i, n) ? 2 : 1);
                if (nxt <= PAT) s[nxt] = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic t_pos start_positions(int n);
        t_pos s;
        s    = '0;
        s[0] = 1'b1;
        return close_skips(s, n);
    endfunction

    // one character step of the position set
    function automatic t_pos advance_positions(t_pos s, logic [7:0] c, int n);
        t_pos       nx;
        logic [7:0] p;
        bit         sep_ok;
        nx     = '0;
        sep_ok = !(cfg_sep && (c == gwm_pkg::C_SLASH || c == gwm_pkg::C_DOT
                               || c == gwm_pkg::C_COLON));
        for (int i = 0; i < n; i++) begin
            if (s[i]) begin
                p = pat_char_at(i);
                if (p == gwm_pkg::C_STAR) begin
                    // double star stays put on any character
                    if (pairs_star(i, n) || sep_ok) nx[i] = 1'b1;
                end else if (p == gwm_pkg::C_QMARK) begin
                    if (sep_ok) nx[i+1] = 1'b1;
                end else if (p == c) begin
                    nx[i+1] = 1'b1;
                end
            end
        end
        return close_skips(nx, n);
    endfunction

    // ---------------------------------------------------------------
    // monitor: shadow config, prediction, result check, watchdog
    // all sampling happens on pre-edge values at the rising edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        int   n;
        logic exp_bit;
        if (!i_rst_n) begin
            cfg_lo    = '0;
            cfg_hi    = '0;
            cfg_len   = '0;
            cfg_sep   = 1'b0;
            reach_set = '0;
        end else begin
            // result transaction: compare with the oldest prediction
            if (pop && !empty) begin
                if (match_pred_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual whole_match=%0b",
                             $time, o_whole_match);
                    mismatch_count++;
                end else begin
                    exp_bit = match_pred_q.pop_front();
                    if (o_whole_match !== exp_bit) begin
                        $display("%0t: whole_match mismatch, expected %0b, actual %0b",
                                 $time, exp_bit, o_whole_match);
                        mismatch_count++;
                    end
                end
            end
            // register write
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gwm_pkg::CFG_PAT_LOW:  cfg_lo  = i_cfg_data;
                    gwm_pkg::CFG_PAT_HIGH: cfg_hi  = i_cfg_data;
                    gwm_pkg::CFG_PAT_LEN:  cfg_len = i_cfg_data[gwm_pkg::C_LEN_W-1:0];
                    gwm_pkg::CFG_SEP_MODE: cfg_sep = i_cfg_data[0];
                    default: ;
                endcase
            end
            // request transaction: step the shadow position set
            if (push && !full) begin
                n = live_len();
                case (i_req_type)
                    gwm_pkg::REQ_EMPTY: reach_set = start_positions(n);
                    gwm_pkg::REQ_FIRST: reach_set = advance_positions(start_positions(n),
                                                                      i_value_char, n);
                    gwm_pkg::REQ_NEXT:  reach_set = advance_positions(reach_set,
                                                                      i_value_char, n);
                    default: ;
                endcase
                match_pred_q.insert(match_pred_q.size(), reach_set[n]);
            end
            // watchdog on cycles with no transaction on either side
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // random wait per transaction, with occasional stretches of none at all
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 31) == 0) calm = ~calm;
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    // result side: pop with random stalls for the whole run
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_gap(rx_calm);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end

    // one request transaction; push stays high on return so that
    // back-to-back transactions never lower and raise it in one step
    task automatic send_item(logic [1:0] req, logic [7:0] ch);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_req_type   <= req;
        i_value_char <= ch;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sent_items++;
    endtask

    // a value string, first character with the given request code
    task automatic send_str(string s, logic [1:0] lead);
        for (int k = 0; k < s.len(); k++)
            send_item((k == 0) ? lead : gwm_pkg::REQ_NEXT, s[k]);
    endtask

    // stop requests and let every predicted result come out
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (match_pred_q.size() != 0) @(posedge i_clk);
        // margin before the next phase
        repeat (3) @(posedge i_clk);
    endtask

    // write all four registers on an idle block
    task automatic load_pattern(logic [63:0] lo, logic [63:0] hi,
                                logic [63:0] len_word, logic [63:0] sep_word);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= gwm_pkg::CFG_PAT_LOW;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        i_cfg_index <= gwm_pkg::CFG_PAT_HIGH;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        i_cfg_index <= gwm_pkg::CFG_PAT_LEN;
        i_cfg_data  <= len_word;
        @(posedge i_clk);
        i_cfg_index <= gwm_pkg::CFG_SEP_MODE;
        i_cfg_data  <= sep_word;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // byte k of the string lands in bits 8k+7..8k
    function automatic logic [63:0] pack_chars(string s);
        logic [63:0] r;
        r = '0;
        for (int k = 0; k < s.len() && k < 8; k++) r[8*k +: 8] = s[k];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // random pattern and value generation
    // ---------------------------------------------------------------

    function automatic logic [7:0] pick_pat_char();
        int r;
        r = $urandom_range(0, 19);
        if (r < 5) return gwm_pkg::C_STAR;
        if (r < 7) return gwm_pkg::C_QMARK;
        if (r == 7) return gwm_pkg::C_SLASH;
        if (r == 8) return gwm_pkg::C_DOT;
        if (r == 9) return gwm_pkg::C_COLON;
        if (r == 19) return 8'($urandom_range(0, 255));
        return 8'h61 + 8'(r % 3);
    endfunction

    // a character for a wildcard to eat; separators only where allowed
    function automatic logic [7:0] filler(bit allow_sep);
        int r;
        r = $urandom_range(0, 15);
        if (allow_sep && r < 4) begin
            case (r % 3)
                0:       return gwm_pkg::C_SLASH;
                1:       return gwm_pkg::C_DOT;
                default: return gwm_pkg::C_COLON;
            endcase
        end
        if (r == 15) return 8'($urandom_range(0, 255));
        return 8'h61 + 8'(r % 3);
    endfunction

    // walk the pattern to build a value that should match, then maybe break it
    function automatic void build_value(int n, bit sep);
        int         i;
        int         r;
        logic [7:0] c;
        bit         dbl;
        word_q.delete();
        i = 0;
        while (i < n) begin
            c = pat_b[i];
            if (c == gwm_pkg::C_STAR) begin
                dbl = (i + 1 < n) && (pat_b[i+1] == gwm_pkg::C_STAR);
                repeat ($urandom_range(0, 3))
                    word_q.insert(word_q.size(), filler(dbl || !sep));
                i += dbl ? 2 : 1;
            end else if (c == gwm_pkg::C_QMARK) begin
                word_q.insert(word_q.size(), filler(!sep));
                i++;
            end else begin
                word_q.insert(word_q.size(), c);
                i++;
            end
        end
        r = $urandom_range(0, 9);
        if (r < 2 && word_q.size() > 0)
            word_q[$urandom_range(0, word_q.size() - 1)] = filler(1'b1);
        else if (r == 2 && word_q.size() > 0)
            word_q.delete($urandom_range(0, word_q.size() - 1));
        else if (r == 3)
            word_q.insert($urandom_range(0, word_q.size()), filler(1'b1));
    endfunction

    // one value: mostly well formed, some empty values and noise
    task automatic send_random_value(int n, bit sep, bit may_continue);
        int  r;
        bit  cont;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            send_item(gwm_pkg::REQ_EMPTY, 8'($urandom_range(0, 255)));
        end else if (r == 1) begin
            send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end else begin
            build_value(n, sep);
            // sometimes carry on with the value left from the last setting
            cont = may_continue && ($urandom_range(0, 2) == 0);
            if (word_q.size() == 0)
                send_item(gwm_pkg::REQ_EMPTY, 8'($urandom_range(0, 255)));
            for (int k = 0; k < word_q.size(); k++)
                send_item((k == 0 && !cont) ? gwm_pkg::REQ_FIRST : gwm_pkg::REQ_NEXT,
                          word_q[k]);
        end
    endtask

    task automatic run_random_phase(int budget);
        int          plen;
        int          n;
        int          r;
        int          first_item;
        bit          sep;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] len_word;
        logic [63:0] sep_word;
        r = $urandom_range(0, 15);
        if (r == 0)      plen = 0;
        else if (r == 1) plen = PAT;
        else if (r == 2) plen = $urandom_range(PAT + 1, 31);
        else             plen = $urandom_range(1, 10);
        n = (plen > PAT) ? PAT : plen;
        // unused tail bytes are random; now and then the whole pattern is
        r = $urandom_range(0, 11);
        for (int i = 0; i < PAT; i++)
            pat_b[i] = (i < n && r != 0) ? pick_pat_char() : 8'($urandom_range(0, 255));
        for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = pat_b[i];
            hi[8*i +: 8] = pat_b[i+8];
        end
        sep = $urandom_range(0, 1);
        // upper data bits are don't-care for the narrow registers
        len_word      = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
        len_word[4:0] = 5'(plen);
        sep_word      = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
        sep_word[0]   = sep;
        load_pattern(lo, hi, len_word, sep_word);
        first_item = sent_items;
        send_random_value(n, sep, 1'b1);
        while (sent_items - first_item < budget) send_random_value(n, sep, 1'b0);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset config: zero length, empty position set
    task automatic test_reset_defaults();
        send_item(gwm_pkg::REQ_NEXT, 8'h61);     // no value started, stays unmatched
        send_item(REQ_UNUSED, 8'h62);
        send_item(gwm_pkg::REQ_EMPTY, 8'h00);    // empty value vs empty pattern
        send_item(gwm_pkg::REQ_FIRST, 8'hFF);
    endtask

    // literal compare at the byte extremes
    task automatic test_exact_chars();
        load_pattern(64'h0000_0000_0061_FF00, 64'd0, 64'd3, 64'd0);
        send_item(gwm_pkg::REQ_FIRST, 8'h00);
        send_item(gwm_pkg::REQ_NEXT, 8'hFF);
        send_item(gwm_pkg::REQ_NEXT, 8'h61);
        send_item(REQ_UNUSED, 8'h00);   // report only, no step
    endtask

    // single star and question mark with and without separator mode
    task automatic test_single_wildcards();
        load_pattern(pack_chars("a*?"), 64'd0, 64'd3, 64'd1);
        send_str("ax/", gwm_pkg::REQ_FIRST);     // slash kills both wildcards
        load_pattern(pack_chars("a*?"), 64'd0, 64'd3, 64'd0);
        send_str("a:.", gwm_pkg::REQ_FIRST);
    endtask

    // double star crosses every separator
    task automatic test_double_star();
        load_pattern(pack_chars("a**b"), 64'd0, 64'd4, 64'd1);
        send_str("a/.:b", gwm_pkg::REQ_FIRST);
    endtask

    // lengths past capacity behave as full capacity
    task automatic test_length_clamp();
        load_pattern(pack_chars("********"), pack_chars("*******x"), 64'd31, 64'd1);
        send_item(gwm_pkg::REQ_EMPTY, 8'h00);
        send_item(gwm_pkg::REQ_FIRST, 8'h78);
        load_pattern(pack_chars("********"), pack_chars("*******x"), 64'd17, 64'd0);
        send_item(gwm_pkg::REQ_FIRST, 8'h78);
    endtask

    // position set survives a config change inside a value
    task automatic test_reconfig_mid_value();
        load_pattern(pack_chars("ab"), 64'd0, 64'd2, 64'd0);
        send_item(gwm_pkg::REQ_FIRST, 8'h61);
        load_pattern(pack_chars("ab"), 64'd0, 64'd1, 64'd0);
        send_item(REQ_UNUSED, 8'h00);   // now reads the bit at the shorter length
        send_item(gwm_pkg::REQ_NEXT, 8'h62);     // a position at the length never moves
        load_pattern(pack_chars("ab"), 64'd0, 64'd2, 64'd0);
        send_item(gwm_pkg::REQ_NEXT, 8'h62);
    endtask

    task automatic test_random_traffic();
        while (sent_items < ITEM_TARGET) run_random_phase($urandom_range(20, 80));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_exact_chars();
        test_single_wildcards();
        test_double_star();
        test_length_clamp();
        test_reconfig_mid_value();
        test_random_traffic();
        settle();
        if (mismatch_count == 0 && match_pred_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/gwm_pkg.sv
hw/rtl/gwm_fifo.sv
hw/rtl/gwm_front.sv
hw/rtl/gwm_back.sv
hw/rtl/glob_wildcard_matcher.sv
hw/rtl/gwm_checker.sv
verif/tb.sv
